// File: hdl/ctst_pkg.sv
// Shared types, constants and codes of the cooperative task scheduler table.
package ctst_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int TICK_MS     = 10;
    localparam int RESULT_CAP  = 16;
    localparam int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW          = $clog2(MAX_ENTRIES + 1);
    localparam logic [7:0] PENDING_MAX = 8'hFF;

    // Reciprocal of the tick length: quotient = (x * DIV_MAGIC) >> (32 + DIV_SHIFT),
    // exact for every 32-bit dividend.
    localparam int DIV_SHIFT = $clog2(TICK_MS);
    localparam logic [32:0] DIV_MAGIC =
        33'(((64'd1 << (32 + DIV_SHIFT)) / 64'(TICK_MS)) + 64'd1);

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_DELETE   = 2'd2,
        MODE_DISPATCH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        KIND_DONE    = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_NO_SLOT = 3'd2,
        KIND_RUN     = 3'd3,
        KIND_NONE    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_DEC   = 3'd3,
        CMD_SHIFT = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_DISP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  task_tag;
        logic [31:0] delay_ms;
        logic [31:0] period_ms;
        logic [3:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        t_kind      result_kind;
        logic [7:0] run_tag;
        logic [3:0] run_slot;
        logic [4:0] entry_count;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pending;
    } t_entry;

    // Command broadcast along the row of cells.
    typedef struct packed {
        t_op           op;
        logic [IW-1:0] idx;
        logic [CW-1:0] total;
        t_entry        entry;
    } t_cmd;

endpackage

// File: hdl/ctst_cell.sv
// One table cell: holds a single task entry and acts on the broadcast command.
module ctst_cell (
    input  logic                    i_clk,
    input  ctst_pkg::t_cmd          i_cmd,
    input  logic [ctst_pkg::IW-1:0] i_pos,
    input  ctst_pkg::t_entry        i_next,
    output ctst_pkg::t_entry        o_entry
);

    ctst_pkg::t_entry r_entry;
    ctst_pkg::t_entry n_entry;

    // Next entry according to the command and this cell's position.
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            ctst_pkg::CMD_TICK: begin
                if (32'(i_pos) < 32'(i_cmd.total)) begin
                    if (r_entry.delay != 32'd0) begin
                        n_entry.delay = r_entry.delay - 32'd1;
                    end else begin
                        n_entry.delay = r_entry.period;
                        if (r_entry.pending != ctst_pkg::PENDING_MAX) begin
                            n_entry.pending = r_entry.pending + 8'd1;
                        end
                    end
                end
            end
            ctst_pkg::CMD_LOAD: begin
                if (i_pos == i_cmd.idx) begin
                    n_entry = i_cmd.entry;
                end
            end
            ctst_pkg::CMD_DEC: begin
                if (i_pos == i_cmd.idx) begin
                    n_entry.pending = r_entry.pending - 8'd1;
                end
            end
            ctst_pkg::CMD_SHIFT: begin
                if (i_pos >= i_cmd.idx) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: hdl/ctst_div.sv
// Division by the tick length through reciprocal multiplication.
module ctst_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    output logic        o_busy,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic [64:0] r_prod;
    logic [31:0] r_quo;

    // Busy for the one cycle in which the product is scaled down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // Product and quotient carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= 65'(i_dividend) * 65'(ctst_pkg::DIV_MAGIC);
        end
        if (r_busy) begin
            r_quo <= 32'(r_prod >> (32 + ctst_pkg::DIV_SHIFT));
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: hdl/cooperative_task_scheduler_table_top.sv
// Top level of the cooperative task scheduler table: control, cell row and result buffer.

// A tick or a delete gives one result. An add to a full table gives a full
// result; otherwise delay and period are multiplied by the reciprocal of the
// tick length in the accepting cycle, scaled down to ticks in the next, and
// the entry is written once the output register is free. A dispatch walks the
// row of cells one entry per cycle through a single read port, and then sends
// its buffered results (or a single none result if it has none) one per cycle
// while the output is not stalled; every result of a dispatch carries the final
// entry count. A new transaction is taken only once the previous one has been
// fully delivered into the output register.
module cooperative_task_scheduler_table_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ctst_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ctst_pkg::t_out_item o_out_data
);

    ctst_pkg::t_state    r_state;
    ctst_pkg::t_state    n_state;
    logic [ctst_pkg::CW-1:0] r_total;
    logic [ctst_pkg::CW-1:0] n_total;
    logic [ctst_pkg::CW-1:0] r_idx;
    logic [ctst_pkg::CW-1:0] n_idx;
    logic [4:0]          r_nres;
    logic [4:0]          n_nres;
    logic [4:0]          r_eidx;
    logic [4:0]          n_eidx;
    logic [7:0]          r_buf_tag  [ctst_pkg::RESULT_CAP];
    logic [3:0]          r_buf_slot [ctst_pkg::RESULT_CAP];
    logic                r_out_valid;
    logic                n_out_valid;
    ctst_pkg::t_out_item r_out;
    ctst_pkg::t_out_item n_out;
    logic                w_buf_we;
    logic [7:0]          w_buf_tag;
    logic [3:0]          w_buf_slot;
    logic                w_out_free;
    logic                w_in_accept;
    logic                w_div_start;
    logic                w_busy_a;
    logic                w_busy_b;
    logic [31:0]         w_quo_a;
    logic [31:0]         w_quo_b;
    ctst_pkg::t_cmd      w_cmd;
    ctst_pkg::t_entry    w_cells [ctst_pkg::MAX_ENTRIES];
    ctst_pkg::t_entry    w_rd;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ctst_pkg::S_IDLE) && w_out_free);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_rd        = w_cells[r_idx[ctst_pkg::IW-1:0]];

    // Dividers for delay and period.
    ctst_div u_div_delay (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_data.delay_ms),
        .o_busy     (w_busy_a),
        .o_quotient (w_quo_a)
    );

    ctst_div u_div_period (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_data.period_ms),
        .o_busy     (w_busy_b),
        .o_quotient (w_quo_b)
    );

    // Row of cells, each but the top shifting from its upper neighbour on removal.
    for (genvar g = 0; g < ctst_pkg::MAX_ENTRIES; g++) begin : g_cell
        ctst_pkg::t_entry w_next;
        if (g == ctst_pkg::MAX_ENTRIES - 1) begin : g_end
            assign w_next = w_cells[g];
        end else begin : g_mid
            assign w_next = w_cells[g + 1];
        end
        ctst_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (ctst_pkg::IW'(g)),
            .i_next  (w_next),
            .o_entry (w_cells[g])
        );
    end

    // Sequencer: command issue, dispatch walk and result emission.
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_idx       = r_idx;
        n_nres      = r_nres;
        n_eidx      = r_eidx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_div_start = 1'b0;
        w_buf_we    = 1'b0;
        w_buf_tag   = w_rd.tag;
        w_buf_slot  = 4'(r_idx);
        w_cmd       = '0;
        w_cmd.op    = ctst_pkg::CMD_NONE;
        w_cmd.total = r_total;
        w_cmd.idx   = r_total[ctst_pkg::IW-1:0];
        case (r_state)
            ctst_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_out             = '0;
                    n_out.result_kind = ctst_pkg::KIND_DONE;
                    n_out.entry_count = 5'(r_total);
                    n_out.last        = 1'b1;
                    case (i_in_data.mode)
                        ctst_pkg::MODE_TICK: begin
                            w_cmd.op    = ctst_pkg::CMD_TICK;
                            n_out_valid = 1'b1;
                        end
                        ctst_pkg::MODE_ADD: begin
                            if (32'(r_total) < 32'(ctst_pkg::MAX_ENTRIES)) begin
                                w_div_start = 1'b1;
                                n_state     = ctst_pkg::S_DIV;
                            end else begin
                                n_out.result_kind = ctst_pkg::KIND_FULL;
                                n_out_valid       = 1'b1;
                            end
                        end
                        ctst_pkg::MODE_DELETE: begin
                            if (32'(i_in_data.slot_index) < 32'(r_total)) begin
                                w_cmd.op          = ctst_pkg::CMD_SHIFT;
                                w_cmd.idx         = ctst_pkg::IW'(i_in_data.slot_index);
                                n_total           = r_total - 1'b1;
                                n_out.entry_count = 5'(r_total - 1'b1);
                            end else begin
                                n_out.result_kind = ctst_pkg::KIND_NO_SLOT;
                            end
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            n_idx   = '0;
                            n_nres  = '0;
                            n_state = ctst_pkg::S_DISP;
                        end
                    endcase
                end
            end
            ctst_pkg::S_DIV: begin
                if (!w_busy_a && w_out_free) begin
                    w_cmd.op            = ctst_pkg::CMD_LOAD;
                    w_cmd.entry.tag     = r_out.run_tag;
                    w_cmd.entry.delay   = w_quo_a;
                    w_cmd.entry.period  = w_quo_b;
                    w_cmd.entry.pending = 8'd0;
                    n_total             = r_total + 1'b1;
                    n_out               = '0;
                    n_out.result_kind   = ctst_pkg::KIND_DONE;
                    n_out.entry_count   = 5'(r_total + 1'b1);
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    n_state             = ctst_pkg::S_IDLE;
                end
            end
            ctst_pkg::S_DISP: begin
                if ((r_idx < r_total) && (r_nres < 5'(ctst_pkg::RESULT_CAP))) begin
                    if (w_rd.pending != 8'd0) begin
                        w_buf_we  = 1'b1;
                        n_nres    = r_nres + 5'd1;
                        w_cmd.idx = r_idx[ctst_pkg::IW-1:0];
                        if (w_rd.period == 32'd0) begin
                            // A one-shot task leaves; the next entry slides into this slot.
                            w_cmd.op = ctst_pkg::CMD_SHIFT;
                            n_total  = r_total - 1'b1;
                        end else begin
                            w_cmd.op = ctst_pkg::CMD_DEC;
                            n_idx    = r_idx + 1'b1;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_eidx  = '0;
                    n_state = ctst_pkg::S_EMIT;
                end
            end
            ctst_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_out             = '0;
                    n_out.entry_count = 5'(r_total);
                    n_out_valid       = 1'b1;
                    if (r_nres == 5'd0) begin
                        n_out.result_kind = ctst_pkg::KIND_NONE;
                        n_out.last        = 1'b1;
                        n_state           = ctst_pkg::S_IDLE;
                    end else begin
                        n_out.result_kind = ctst_pkg::KIND_RUN;
                        n_out.run_tag     = r_buf_tag[r_eidx[3:0]];
                        n_out.run_slot    = r_buf_slot[r_eidx[3:0]];
                        n_out.last        = (r_eidx == r_nres - 5'd1);
                        n_eidx            = r_eidx + 5'd1;
                        if (r_eidx == r_nres - 5'd1) begin
                            n_state = ctst_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ctst_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctst_pkg::S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers; the add tag waits in the output register's tag field.
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_nres <= n_nres;
        r_eidx <= n_eidx;
        if (w_div_start) begin
            r_out         <= '0;
            r_out.run_tag <= i_in_data.task_tag;
        end else begin
            r_out <= n_out;
        end
        if (w_buf_we) begin
            r_buf_tag[r_nres[3:0]]  <= w_buf_tag;
            r_buf_slot[r_nres[3:0]] <= w_buf_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The table never holds more entries than it has cells.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= 32'(ctst_pkg::MAX_ENTRIES))
        else $error("entry total beyond table size");

    // Both dividers run in lock step.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy_a == w_busy_b)
        else $error("dividers out of step");

    // An accepted transaction either yields a result at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_out_valid || (r_state != ctst_pkg::S_IDLE)))
        else $error("accepted transaction lost");

    // The final result of a dispatch returns the block to idle.
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ctst_pkg::S_EMIT) && w_out_free && n_out.last)
        |=> (r_state == ctst_pkg::S_IDLE))
        else $error("dispatch did not finish after last result");

endmodule
